>>> hdl/sgsq_pkg.sv
`default_nettype none
package sgsq_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int EPS_WIDTH      = 31;

    localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(1);

    // Codes of the func field.
    localparam logic FUNC_FWD = 1'b0;
    localparam logic FUNC_BWD = 1'b1;

    // Control that travels with every item along the cell chain.
    typedef struct packed {
        logic valid;
        logic func;
        logic neg;
        logic dz;
    } sgsq_ctl_t;

endpackage
`default_nettype wire

>>> hdl/sgsq_cell.sv
`default_nettype none
module sgsq_cell
    import sgsq_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int SQ_STEPS = 24,
    parameter int W2       = 48,
    parameter int RW       = 36,
    parameter int QW       = 48,
    parameter int DENW     = 34
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire sgsq_ctl_t       ctl_in,
    input  wire logic [W2-1:0]   num_in,
    input  wire logic [DENW-1:0] den_in,
    input  wire logic [RW-1:0]   rem_in,
    input  wire logic [QW-1:0]   acc_in,
    output sgsq_ctl_t            ctl_out,
    output logic [W2-1:0]        num_out,
    output logic [DENW-1:0]      den_out,
    output logic [RW-1:0]        rem_out,
    output logic [QW-1:0]        acc_out
);

    localparam bit SQ_ACTIVE = (IDX < SQ_STEPS);

    sgsq_ctl_t       ctl_reg;
    logic [W2-1:0]   num_reg, num_next;
    logic [DENW-1:0] den_reg;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [QW-1:0]   acc_reg, acc_next;

    logic [RW-1:0] remx;
    logic [RW-1:0] trial;

    // One restoring step: two bits of radicand for the root (only in the first
    // SQ_STEPS cells; later cells pass root items through), one bit of dividend for the quotient.
    always_comb begin
        remx     = '0;
        trial    = '0;
        num_next = num_in;
        rem_next = rem_in;
        acc_next = acc_in;
        if (ctl_in.func == FUNC_BWD) begin
            remx     = RW'({rem_in, num_in[W2-1]});
            trial    = RW'(den_in);
            num_next = num_in << 1;
            if (remx >= trial) begin
                rem_next = remx - trial;
                acc_next = QW'({acc_in, 1'b1});
            end else begin
                rem_next = remx;
                acc_next = QW'({acc_in, 1'b0});
            end
        end else if (SQ_ACTIVE) begin
            remx     = RW'({rem_in, num_in[W2-1:W2-2]});
            trial    = RW'({acc_in, 2'b01});
            num_next = num_in << 2;
            if (remx >= trial) begin
                rem_next = remx - trial;
                acc_next = QW'({acc_in, 1'b1});
            end else begin
                rem_next = remx;
                acc_next = QW'({acc_in, 1'b0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            den_reg <= den_in;
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign acc_out = acc_reg;

endmodule
`default_nettype wire

>>> hdl/signed_sqrt_with_gradient.sv
`default_nettype none
// Path: from the input register through the step-cell chain to the output register.
// Throughput: one item per cycle; the chain of DATA_WIDTH + FRAC_BITS step cells is fully
// pipelined and the whole chain advances whenever the output register is free or being taken.
// Reset: aresetn is synchronous and active low; it clears all valid bits and sets epsilon to 1.
module signed_sqrt_with_gradient
    import sgsq_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int ITW = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OTW = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [EPS_WIDTH-1:0] cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tdata: first_value, upstream_gradient, zero padding
    input  wire logic [ITW-1:0]       s_tdata,
    // tuser: func
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // tdata: result_value, zero padding
    output logic [OTW-1:0]            m_tdata,
    // tuser: saturated
    output logic                      m_tuser
);

    localparam int D     = DATA_WIDTH;
    localparam int N     = DATA_WIDTH + FRAC_BITS;
    localparam int S     = (N + 1) / 2;
    localparam int W2    = 2 * S;
    localparam int DENW  = ((D > EPS_WIDTH) ? D : EPS_WIDTH) + 2;
    localparam int RW    = ((S + 3) > (DENW + 1)) ? (S + 3) : (DENW + 1);
    localparam int QW    = N;
    localparam int ALIGN = W2 - N;

    // The epsilon register is the only configuration state.
    logic [EPS_WIDTH-1:0] eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    // Whole pipeline moves together; it stalls only while a result waits.
    logic en;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Input stage: magnitudes, signs, denominator and numerator (left-aligned for the backward func).
    logic [D-1:0]    fv, gv, fmag, gmag;
    logic            fneg, gneg;
    logic [DENW-1:0] den_c;
    logic [W2-1:0]   num_c;
    sgsq_ctl_t       ctl_c;

    always_comb begin
        fv    = s_tdata[D-1:0];
        gv    = s_tdata[2*D-1:D];
        fneg  = fv[D-1];
        gneg  = gv[D-1];
        fmag  = fneg ? (~fv + D'(1)) : fv;
        gmag  = gneg ? (~gv + D'(1)) : gv;
        den_c = (DENW'(fmag) + DENW'(eps_reg)) << 1;
        if (s_tuser == FUNC_BWD) begin
            num_c = (W2'(gmag) << FRAC_BITS) << ALIGN;
        end else begin
            num_c = W2'(fmag) << FRAC_BITS;
        end
        ctl_c.valid = s_tvalid;
        ctl_c.func  = s_tuser;
        ctl_c.neg   = (s_tuser == FUNC_BWD) ? gneg : fneg;
        ctl_c.dz    = (s_tuser == FUNC_BWD) && (den_c == '0);
    end

    sgsq_ctl_t       p_ctl_reg;
    logic [W2-1:0]   p_num_reg;
    logic [DENW-1:0] p_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctl_reg <= '0;
        end else if (en) begin
            p_ctl_reg <= ctl_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_num_reg <= num_c;
            p_den_reg <= den_c;
        end
    end

    // Chain of step cells. Cell i hands its partial remainder and result to cell i+1.
    sgsq_ctl_t       c_ctl [0:N];
    logic [W2-1:0]   c_num [0:N];
    logic [DENW-1:0] c_den [0:N];
    logic [RW-1:0]   c_rem [0:N];
    logic [QW-1:0]   c_acc [0:N];

    assign c_ctl[0] = p_ctl_reg;
    assign c_num[0] = p_num_reg;
    assign c_den[0] = p_den_reg;
    assign c_rem[0] = '0;
    assign c_acc[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        sgsq_cell #(
            .IDX      (i),
            .SQ_STEPS (S),
            .W2       (W2),
            .RW       (RW),
            .QW       (QW),
            .DENW     (DENW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctl_in  (c_ctl[i]),
            .num_in  (c_num[i]),
            .den_in  (c_den[i]),
            .rem_in  (c_rem[i]),
            .acc_in  (c_acc[i]),
            .ctl_out (c_ctl[i+1]),
            .num_out (c_num[i+1]),
            .den_out (c_den[i+1]),
            .rem_out (c_rem[i+1]),
            .acc_out (c_acc[i+1])
        );
    end

    // Output stage: clip to the signed range and apply the sign.
    sgsq_ctl_t     l_ctl;
    logic [QW-1:0] limit, mag_o;
    logic          over;
    logic [D-1:0]  res_c;

    always_comb begin
        l_ctl = c_ctl[N];
        limit = (QW'(1) << (D - 1)) - QW'(!l_ctl.neg);
        over  = l_ctl.dz || (c_acc[N] > limit);
        mag_o = over ? limit : c_acc[N];
        res_c = l_ctl.neg ? (~D'(mag_o) + D'(1)) : D'(mag_o);
    end

    logic [D-1:0] m_data_reg;
    logic         m_sat_reg;
    logic         m_dz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= l_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= res_c;
            m_sat_reg  <= over;
            m_dz_reg   <= l_ctl.dz;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OTW'(m_data_reg);
    assign m_tuser  = m_sat_reg;

    // A zero denominator must always come out flagged as saturated.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_dz_reg) |-> m_sat_reg)
        else $error("zero denominator without saturation flag");

    // The input side is stalled exactly while a result is held back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // No result is presented in the cycle after reset.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid_reg)
        else $error("output valid right after reset");

endmodule
`default_nettype wire
